### rtl/shared_buffer_multi_queue_top_defines.svh
// Assertion macros shared by the queue manager RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
// The macros expect a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef SHARED_BUFFER_MULTI_QUEUE_TOP_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define SBMQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbmq: assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SBMQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbmq: assertion failed");
`else
`define SBMQ_ASSERT_IMP(name, ante, cons)
`define SBMQ_ASSERT_NXT(name, ante, cons)
`endif
`endif

### rtl/sbmq_pkg.sv
// Package for the shared-buffer multi-queue manager: field widths, default sizes,
// command and status codes, and the store control struct. No dependencies.
package sbmq_pkg;

  localparam int unsigned SLOTS_DEF      = 16;
  localparam int unsigned QUEUES_DEF     = 4;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned QID_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Strobes from the queue engine to the slot store.
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic data_we;
  } mem_ctl_t;

endpackage

### rtl/sbmq_if.sv
// Request and response channel interfaces of the queue manager.
// Depends on sbmq_pkg for the field widths.
interface sbmq_req_if;
  import sbmq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic        [QID_W-1:0]   queue_id;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, queue_id, value, input ready);
  modport sink   (input valid, command, queue_id, value, output ready);
endinterface

interface sbmq_rsp_if;
  import sbmq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  data_out;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, data_out, status, input ready);
  modport sink   (input valid, data_out, status, output ready);
endinterface

### rtl/shared_buffer_multi_queue_top.sv
// Top level of the shared-buffer multi-queue manager.
// Depends on sbmq_pkg, sbmq_if, sbmq_store and sbmq_engine.
//
// Channel | Modport         | Payload                            | Taken when
// req_i   | sbmq_req_if.sink   | command, queue_id, value        | valid && ready
// rsp_o   | sbmq_rsp_if.source | data_out, status                | valid && ready
//
// Each request is captured in the request register while the slot store is read, and
// its result is then loaded into the result register once that register is free or is
// being emptied. A new request is taken every clock while rsp_o takes results, so the
// sustained rate is one request per cycle. The rate is set by the single update step
// over the queue table, the free list and the store's one read port, whose address
// is forwarded from the request still in the register. Reset clears the queue busy
// flags and the free-list head and fill mark at once; the stores are never swept,
// because slots above the fill mark are known to chain in ascending order. Requests
// are taken right after reset. A result that waits on rsp_o holds the request
// register, and req_i.ready falls only when both the result register and the
// request register are occupied.
module shared_buffer_multi_queue_top #(
  parameter int unsigned SLOTS      = sbmq_pkg::SLOTS_DEF,
  parameter int unsigned QUEUES     = sbmq_pkg::QUEUES_DEF,
  parameter int unsigned DATA_WIDTH = sbmq_pkg::DATA_WIDTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  sbmq_req_if.sink   req_i,
  sbmq_rsp_if.source rsp_o
);
  import sbmq_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned PW = $clog2(SLOTS + 1);

  logic               in_fire;
  logic               s1_valid;
  logic               s1_go;
  logic [VALUE_W-1:0] res_data;
  status_e            res_status;
  mem_ctl_t           mem_ctl;

  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         link_waddr;
  logic [PW-1:0]         link_wdata;
  logic [IW-1:0]         data_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic [PW-1:0]         link_rd;
  logic [DATA_WIDTH-1:0] data_rd;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_data_q;
  status_e            out_status_q;

  // The request in the register completes when the result register is free or
  // is being emptied in the same cycle.
  assign s1_go       = s1_valid && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid || s1_go;
  assign in_fire     = req_i.valid && req_i.ready;

  sbmq_engine #(
    .SLOTS      (SLOTS),
    .QUEUES     (QUEUES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .in_command_i  (req_i.command),
    .in_queue_id_i (req_i.queue_id),
    .in_value_i    (req_i.value),
    .s1_go_i       (s1_go),
    .s1_valid_o    (s1_valid),
    .res_data_o    (res_data),
    .res_status_o  (res_status),
    .mem_ctl_o     (mem_ctl),
    .rd_addr_o     (rd_addr),
    .link_waddr_o  (link_waddr),
    .link_wdata_o  (link_wdata),
    .data_waddr_o  (data_waddr),
    .data_wdata_o  (data_wdata),
    .link_rd_i     (link_rd),
    .data_rd_i     (data_rd)
  );

  sbmq_store #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .rd_addr_i    (rd_addr),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .data_waddr_i (data_waddr),
    .data_wdata_i (data_wdata),
    .link_rd_o    (link_rd),
    .data_rd_o    (data_rd)
  );

  always_comb begin
    out_valid_d = s1_go || (out_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_data_q   <= res_data;
      out_status_q <= res_status;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.status   = out_status_q;
endmodule

### rtl/sbmq_store.sv
// Slot store: the data words and the next-slot links, one write and one read port each.
// Depends on sbmq_pkg for the control struct.
module sbmq_store #(
  parameter int unsigned SLOTS      = sbmq_pkg::SLOTS_DEF,
  parameter int unsigned DATA_WIDTH = sbmq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  sbmq_pkg::mem_ctl_t           ctl_i,
  input  logic [$clog2(SLOTS)-1:0]     rd_addr_i,
  input  logic [$clog2(SLOTS)-1:0]     link_waddr_i,
  input  logic [$clog2(SLOTS+1)-1:0]   link_wdata_i,
  input  logic [$clog2(SLOTS)-1:0]     data_waddr_i,
  input  logic [DATA_WIDTH-1:0]        data_wdata_i,
  output logic [$clog2(SLOTS+1)-1:0]   link_rd_o,
  output logic [DATA_WIDTH-1:0]        data_rd_o
);
  localparam int unsigned PW = $clog2(SLOTS + 1);

  logic [PW-1:0]         link_mem [SLOTS];
  logic [DATA_WIDTH-1:0] data_mem [SLOTS];
  logic [PW-1:0]         link_rd_q;
  logic [DATA_WIDTH-1:0] data_rd_q;

  // A read that meets a write to the same slot returns the new contents.
  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (ctl_i.rd_en) begin
      if (ctl_i.link_we && (link_waddr_i == rd_addr_i)) begin
        link_rd_q <= link_wdata_i;
      end else begin
        link_rd_q <= link_mem[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.data_we) begin
      data_mem[data_waddr_i] <= data_wdata_i;
    end
    if (ctl_i.rd_en) begin
      if (ctl_i.data_we && (data_waddr_i == rd_addr_i)) begin
        data_rd_q <= data_wdata_i;
      end else begin
        data_rd_q <= data_mem[rd_addr_i];
      end
    end
  end

  assign link_rd_o = link_rd_q;
  assign data_rd_o = data_rd_q;
endmodule

### rtl/sbmq_engine.sv
// Queue engine: request register, queue head/tail table, free list and the update logic.
// Depends on sbmq_pkg and on the assertion macros header.
`include "shared_buffer_multi_queue_top_defines.svh"
module sbmq_engine #(
  parameter int unsigned SLOTS      = sbmq_pkg::SLOTS_DEF,
  parameter int unsigned QUEUES     = sbmq_pkg::QUEUES_DEF,
  parameter int unsigned DATA_WIDTH = sbmq_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_fire_i,
  input  logic                             in_command_i,
  input  logic [sbmq_pkg::QID_W-1:0]       in_queue_id_i,
  input  logic [sbmq_pkg::VALUE_W-1:0]     in_value_i,
  input  logic                             s1_go_i,
  output logic                             s1_valid_o,
  output logic [sbmq_pkg::VALUE_W-1:0]     res_data_o,
  output sbmq_pkg::status_e                res_status_o,
  output sbmq_pkg::mem_ctl_t               mem_ctl_o,
  output logic [$clog2(SLOTS)-1:0]         rd_addr_o,
  output logic [$clog2(SLOTS)-1:0]         link_waddr_o,
  output logic [$clog2(SLOTS+1)-1:0]       link_wdata_o,
  output logic [$clog2(SLOTS)-1:0]         data_waddr_o,
  output logic [DATA_WIDTH-1:0]            data_wdata_o,
  input  logic [$clog2(SLOTS+1)-1:0]       link_rd_i,
  input  logic [DATA_WIDTH-1:0]            data_rd_i
);
  import sbmq_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // Request register.
  logic               s1_valid_q, s1_valid_d;
  cmd_e               s1_cmd_q;
  logic [QID_W-1:0]   s1_qid_q;
  logic [VALUE_W-1:0] s1_value_q;

  // Queue table and free list. Head and tail only mean something while busy is set.
  logic [PW-1:0]     head_q [QUEUES];
  logic [PW-1:0]     head_d [QUEUES];
  logic [PW-1:0]     tail_q [QUEUES];
  logic [PW-1:0]     tail_d [QUEUES];
  logic [QUEUES-1:0] busy_q, busy_d;
  logic [PW-1:0]     free_head_q, free_head_d;
  // Slots at and above the fill mark have never left the free list, which holds
  // them in ascending order behind any recycled slots.
  logic [PW-1:0]     fill_q, fill_d;

  logic          q_ok, cur_busy, free_ok, untouched;
  logic [QW-1:0] qi, in_qi;
  logic          in_q_ok;
  logic [PW-1:0] cur_head, cur_tail, free_next, rd_ptr;

  always_comb begin
    q_ok      = 32'(s1_qid_q) < 32'(QUEUES);
    qi        = QW'(s1_qid_q);
    cur_busy  = q_ok && busy_q[qi];
    cur_head  = head_q[qi];
    cur_tail  = tail_q[qi];
    free_ok   = free_head_q < NIL;
    untouched = free_head_q == fill_q;
    free_next = untouched ? (free_head_q + PW'(1)) : link_rd_i;
  end

  always_comb begin
    head_d            = head_q;
    tail_d            = tail_q;
    busy_d            = busy_q;
    free_head_d       = free_head_q;
    fill_d            = fill_q;
    mem_ctl_o.rd_en   = in_fire_i;
    mem_ctl_o.link_we = 1'b0;
    mem_ctl_o.data_we = 1'b0;
    link_waddr_o      = cur_head[IW-1:0];
    link_wdata_o      = free_head_q;
    data_waddr_o      = free_head_q[IW-1:0];
    data_wdata_o      = DATA_WIDTH'(s1_value_q);
    res_data_o        = '0;
    res_status_o      = ST_DONE;
    if (s1_cmd_q == CMD_ENQ) begin
      if (!q_ok || !free_ok) begin
        res_status_o = ST_OVERFLOW;
      end else if (s1_go_i) begin
        mem_ctl_o.data_we = 1'b1;
        free_head_d       = free_next;
        if (untouched) begin
          fill_d = fill_q + PW'(1);
        end
        if (busy_q[qi]) begin
          mem_ctl_o.link_we = 1'b1;
          link_waddr_o      = cur_tail[IW-1:0];
        end else begin
          head_d[qi] = free_head_q;
        end
        tail_d[qi] = free_head_q;
        busy_d[qi] = 1'b1;
      end
    end else begin
      if (!cur_busy) begin
        res_status_o = ST_EMPTY;
        res_data_o   = '1;
      end else begin
        res_data_o = VALUE_W'($signed(data_rd_i));
        if (s1_go_i) begin
          // The head slot goes back to the front of the free list.
          mem_ctl_o.link_we = 1'b1;
          free_head_d       = cur_head;
          if (cur_head == cur_tail) begin
            busy_d[qi] = 1'b0;
          end else begin
            head_d[qi] = link_rd_i;
          end
        end
      end
    end
  end

  // The store read for an incoming request uses the table as it stands after the
  // request now in the register has been applied.
  always_comb begin
    in_qi   = QW'(in_queue_id_i);
    in_q_ok = 32'(in_queue_id_i) < 32'(QUEUES);
    if ((in_command_i == CMD_DEQ) && in_q_ok) begin
      rd_ptr = head_d[in_qi];
    end else begin
      rd_ptr = free_head_d;
    end
    rd_addr_o = (rd_ptr < NIL) ? rd_ptr[IW-1:0] : '0;
  end

  always_comb begin
    if (in_fire_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_go_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      busy_q      <= '0;
      free_head_q <= '0;
      fill_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      busy_q      <= busy_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_cmd_q   <= cmd_e'(in_command_i);
      s1_qid_q   <= in_queue_id_i;
      s1_value_q <= in_value_i;
    end
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign s1_valid_o = s1_valid_q;

  `SBMQ_ASSERT_IMP(a_free_below_fill, 1'b1, (free_head_q <= fill_q) && (fill_q <= NIL))
  `SBMQ_ASSERT_NXT(a_deq_recycles_head, s1_go_i && (s1_cmd_q == CMD_DEQ) && cur_busy,
                   free_head_q == $past(cur_head))
  `SBMQ_ASSERT_NXT(a_stall_holds_free, s1_valid_q && !s1_go_i, free_head_q == $past(free_head_q))
endmodule

### bench/testbench.sv
// Self-checking bench for the shared-buffer multi-queue manager.
// Needs sbmq_pkg, sbmq_req_if, sbmq_rsp_if and shared_buffer_multi_queue_top.
`timescale 1ns / 1ps

module testbench;
  import sbmq_pkg::*;

  localparam int unsigned NSLOT   = SLOTS_DEF;
  localparam int unsigned NQ      = QUEUES_DEF;
  localparam int unsigned NIL     = NSLOT;
  // Idle margin after the last reply is checked, before the summary is printed.
  localparam int unsigned SETTLE  = 8;
  localparam int unsigned IDLE_PC = 27;

  // One expected reply: the word on data_out and the status code.
  typedef struct packed {
    logic [VALUE_W-1:0] data;
    status_e            status;
  } reply_t;

  logic clk;
  logic rst_n;

  sbmq_req_if req ();
  sbmq_rsp_if rsp ();

  shared_buffer_multi_queue_top #(
    .SLOTS      (NSLOT),
    .QUEUES     (NQ),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Bench copy of the linked-list state. A slot index of NSLOT or more means
  // "no slot", exactly as in the block. The depth and free counters are only
  // used to steer the stimulus, never to predict a reply.
  logic [VALUE_W-1:0] word_store [NSLOT];
  int unsigned        next_slot  [NSLOT];
  int unsigned        head_slot  [NQ];
  int unsigned        tail_slot  [NQ];
  int unsigned        depth      [NQ];
  int unsigned        free_slot;
  int unsigned        slots_free;

  // Replies owed by the block, oldest first.
  reply_t replies_due [$];

  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned overflows_sent;
  int unsigned empties_sent;
  int unsigned replies_checked;

  // When calm is set neither side idles. hold_request asks the reply side to
  // keep ready low for that many cycles.
  bit          calm;
  int unsigned hold_request;

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net against a hung handshake; far beyond the slowest correct run.
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Reset state: every queue empty, all slots chained in ascending order.
  task automatic reset_queue_model();
    for (int unsigned i = 0; i < NSLOT; i++) begin
      word_store[i] = '0;
      next_slot[i]  = i + 1;
    end
    for (int unsigned i = 0; i < NQ; i++) begin
      head_slot[i] = NIL;
      tail_slot[i] = NIL;
      depth[i]     = 0;
    end
    free_slot  = 0;
    slots_free = NSLOT;
  endtask

  // Applies one accepted request to the bench state and returns the reply the
  // block must give. An enqueue takes the head of the free list and links it
  // behind the queue's tail; a dequeue unlinks the queue's head and pushes
  // that slot back on the front of the free list.
  function automatic reply_t predict_reply(input cmd_e cmd, input int unsigned q,
                                           input logic [VALUE_W-1:0] value);
    reply_t      r;
    int unsigned s;
    r.data   = '0;
    r.status = ST_DONE;
    if (q >= NQ) begin
      // A queue number beyond the table addresses nothing.
      r.status = (cmd == CMD_ENQ) ? ST_OVERFLOW : ST_EMPTY;
      r.data   = (cmd == CMD_ENQ) ? '0 : '1;
    end else if (cmd == CMD_ENQ) begin
      if (free_slot >= NSLOT) begin
        r.status = ST_OVERFLOW;
      end else begin
        s         = free_slot;
        free_slot = next_slot[s];
        if (head_slot[q] >= NSLOT) begin
          head_slot[q] = s;
        end else if (tail_slot[q] < NSLOT) begin
          next_slot[tail_slot[q]] = s;
        end
        next_slot[s]  = NIL;
        tail_slot[q]  = s;
        word_store[s] = value;
        depth[q]++;
        slots_free--;
      end
    end else begin
      s = head_slot[q];
      if (s >= NSLOT) begin
        r.status = ST_EMPTY;
        r.data   = '1;
      end else begin
        head_slot[q] = next_slot[s];
        if (head_slot[q] >= NSLOT) begin
          tail_slot[q] = NIL;
        end
        next_slot[s] = free_slot;
        free_slot    = s;
        r.data       = word_store[s];
        depth[q]--;
        slots_free++;
      end
    end
    return r;
  endfunction

  // Offers one request, holding it until the block takes it, then records the
  // reply it is owed. Called at a rising edge and returns at the edge of
  // acceptance, with valid still high so that back-to-back requests need no
  // second assignment in the same step.
  task automatic send_request(input cmd_e cmd, input int unsigned q,
                              input logic [VALUE_W-1:0] value);
    reply_t r;
    if (!calm && $urandom_range(99) < IDLE_PC) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.command  <= cmd;
    req.queue_id <= q[QID_W-1:0];
    req.value    <= value;
    do @(posedge clk); while (!req.ready);
    r = predict_reply(cmd, q, value);
    replies_due.push_back(r);
    requests_sent++;
    if (r.status == ST_OVERFLOW) overflows_sent++;
    if (r.status == ST_EMPTY) empties_sent++;
  endtask

  task automatic enqueue_random();
    send_request(CMD_ENQ, $urandom_range(NQ - 1), $urandom());
  endtask

  // Picks a queue that holds at least one word; the caller makes sure one does.
  function automatic int unsigned pick_busy_queue();
    int unsigned q;
    q = $urandom_range(NQ - 1);
    while (depth[q] == 0) q = (q + 1) % NQ;
    return q;
  endfunction

  task automatic dequeue_busy();
    send_request(CMD_DEQ, pick_busy_queue(), $urandom());
  endtask

  // Stops offering and waits until every owed reply has been checked.
  task automatic wait_for_drain();
    req.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Extremes of the data word, every queue, FIFO order within one queue, and a
  // dequeue from an empty queue on every queue number. The ignored value field
  // of a dequeue carries random bits.
  task automatic test_directed();
    for (int unsigned q = 0; q < NQ; q++) send_request(CMD_DEQ, q, $urandom());
    send_request(CMD_ENQ, 0, 32'h8000_0000);
    send_request(CMD_ENQ, 1, 32'h7FFF_FFFF);
    send_request(CMD_ENQ, 2, 32'h0000_0000);
    send_request(CMD_ENQ, 3, 32'hFFFF_FFFF);
    send_request(CMD_ENQ, 0, 32'h5555_5555);
    send_request(CMD_ENQ, 0, 32'hAAAA_AAAA);
    repeat (3) send_request(CMD_DEQ, 0, $urandom());
    for (int unsigned q = 1; q < NQ; q++) send_request(CMD_DEQ, q, $urandom());
    send_request(CMD_DEQ, 0, $urandom());
  endtask

  // Fills the whole store, tries to overflow it, half drains, refills and
  // overflows again, then empties everything in random queue order.
  task automatic test_fill_and_overflow(input int unsigned rounds);
    repeat (rounds) begin
      while (slots_free != 0) enqueue_random();
      repeat ($urandom_range(1, 3)) enqueue_random();
      repeat (NSLOT / 2) dequeue_busy();
      while (slots_free != 0) enqueue_random();
      enqueue_random();
      while (slots_free != NSLOT) dequeue_busy();
      send_request(CMD_DEQ, $urandom_range(NQ - 1), $urandom());
    end
  endtask

  // Mixed traffic with a chosen share of enqueues. Most dequeues aim at a
  // queue that holds data; about one in eight goes anywhere, empty or not.
  task automatic test_random_traffic(input int unsigned count, input int unsigned enq_pc);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < enq_pc) begin
        enqueue_random();
      end else if (pick % 8 == 0 || slots_free == NSLOT) begin
        send_request(CMD_DEQ, $urandom_range(NQ - 1), $urandom());
      end else begin
        dequeue_busy();
      end
    end
  endtask

  // Back-to-back requests and replies with no idling on either side.
  task automatic test_calm_stretch(input int unsigned count);
    calm = 1'b1;
    test_random_traffic(count, 52);
    calm = 1'b0;
  endtask

  // The reply side holds ready low for a long stretch while requests keep
  // coming, so the result and request registers fill and req ready falls.
  task automatic test_backpressure(input int unsigned rounds);
    repeat (rounds) begin
      hold_request = 80;
      test_random_traffic(30, 55);
    end
  endtask

  // Short bursts, each followed by a pause until every reply is back.
  task automatic test_drain_pauses(input int unsigned bursts);
    repeat (bursts) begin
      test_random_traffic($urandom_range(5, 15), 55);
      wait_for_drain();
    end
  endtask

  // Reply side: drives ready with random idling or a requested hold-off, and
  // checks each reply taken at the edge against the oldest one owed.
  initial begin : reply_checker
    int unsigned hold_left;
    reply_t      want;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with none owed", rsp.data_out, 'x);
        end else begin
          want = replies_due.pop_front();
          if (rsp.data_out !== want.data) begin
            report_mismatch("data_out", rsp.data_out, want.data);
          end
          if (rsp.status !== want.status) begin
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          end
          replies_checked++;
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(99) >= IDLE_PC);
      end
    end
  end

  // Request side and test sequence.
  initial begin
    rst_n           <= 1'b0;
    req.valid       <= 1'b0;
    req.command     <= CMD_ENQ;
    req.queue_id    <= '0;
    req.value       <= '0;
    calm            = 1'b0;
    hold_request    = 0;
    mismatches      = 0;
    requests_sent   = 0;
    overflows_sent  = 0;
    empties_sent    = 0;
    replies_checked = 0;
    reset_queue_model();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_overflow(10);
    test_random_traffic(200, 50);
    test_random_traffic(300, 75);
    test_random_traffic(300, 25);
    test_calm_stretch(200);
    test_backpressure(2);
    test_drain_pauses(5);

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d requests over %0d queues sharing %0d slots:", requests_sent, NQ, NSLOT);
    $display("%0d overflow drops and %0d empty dequeues; checked %0d replies under random",
             overflows_sent, empties_sent, replies_checked);
    $display("idling, long reply hold-offs and drain pauses.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
